[src/sscrc_pkg.sv]
// shared constants, types and crc function for the seeded crc-32c block
`timescale 1ns / 1ps
`default_nettype none
package sscrc_pkg;

    localparam int unsigned MAX_STRUCT_BYTES = 65536;
    localparam int unsigned ID_BYTES         = 16;
    localparam int unsigned LOC_BYTES        = 8;
    localparam int unsigned SEED_BYTES       = ID_BYTES + LOC_BYTES;
    localparam int unsigned POS_W            = $clog2(MAX_STRUCT_BYTES + 1);
    localparam int unsigned STEP_W           = $clog2(SEED_BYTES);
    localparam int unsigned CFG_DATA_W       = 64;
    localparam int unsigned CFG_IDX_W        = 2;
    localparam int unsigned OFF_W            = 16;

    localparam logic [31:0] CRC_POLY = 32'h82F63B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [STEP_W-1:0] SEED_LAST = STEP_W'(SEED_BYTES - 1);
    localparam logic [POS_W-1:0]  POS_MAX   = POS_W'(MAX_STRUCT_BYTES);
    localparam logic [POS_W-1:0]  FIELD_LEN = POS_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_ID_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_ID_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_OFFSET = 2'd2;

    typedef struct packed {
        logic take_plain;
        logic load_first;
        logic seed;
        logic take_held;
    } t_cmd;

    typedef struct packed {
        logic seed_done;
        logic held_last;
        logic out_free;
    } t_status;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
        end
        return x;
    endfunction

endpackage
`default_nettype wire

[src/sscrc_in_if.sv]
// input channel: one structure byte with framing and location
`timescale 1ns / 1ps
`default_nettype none
interface sscrc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic [63:0] location;

    modport source (output valid, output data_byte, output first, output last,
                    output location, input ready);
    modport sink (input valid, input data_byte, input first, input last,
                  input location, output ready);
endinterface
`default_nettype wire

[src/sscrc_out_if.sv]
// output channel: final checksum and its validity flag
`timescale 1ns / 1ps
`default_nettype none
interface sscrc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] checksum;
    logic        valid_res;

    modport source (output valid, output checksum, output valid_res, input ready);
    modport sink (input valid, input checksum, input valid_res, output ready);
endinterface
`default_nettype wire

[src/sscrc_ctrl.sv]
// controller state machine: accept, seed sequence, held byte processing
`timescale 1ns / 1ps
`default_nettype none
module sscrc_ctrl
    import sscrc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_first,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEED = 2'd1;
    localparam logic [1:0] ST_BYTE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == ST_IDLE) && i_status.out_free;
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_first) begin
                        o_cmd.load_first = 1'b1;
                        n_state = ST_SEED;
                    end else begin
                        o_cmd.take_plain = 1'b1;
                    end
                end
            end
            ST_SEED: begin
                o_cmd.seed = 1'b1;
                if (i_status.seed_done) begin
                    n_state = ST_BYTE;
                end
            end
            ST_BYTE: begin
                if (!i_status.held_last || i_status.out_free) begin
                    o_cmd.take_held = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[src/sscrc_dp.sv]
// datapath: config registers, crc register, byte counter, seed selection, result register
`timescale 1ns / 1ps
`default_nettype none
module sscrc_dp
    import sscrc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_last,
    input  wire logic [63:0]           i_location,
    input  wire t_cmd                  i_cmd,
    input  wire logic                  i_out_ready,
    output t_status                    o_status,
    output logic                       o_out_valid,
    output logic [31:0]                o_checksum,
    output logic                       o_valid_res
);

    logic [63:0]       r_id_low;
    logic [63:0]       r_id_high;
    logic [OFF_W-1:0]  r_offset;
    logic [31:0]       r_crc;
    logic [POS_W-1:0]  r_pos;
    logic [STEP_W-1:0] r_step;
    logic [63:0]       r_loc;
    logic [7:0]        r_held_byte;
    logic              r_held_last;
    logic              r_out_valid;
    logic [31:0]       r_checksum;
    logic              r_valid_res;

    logic [63:0]       seed_word;
    logic [7:0]        seed_byte;
    logic [7:0]        cur_byte;
    logic              cur_last;
    logic              take;
    logic [POS_W-1:0]  need;
    logic [POS_W-1:0]  pos_next;
    logic              in_window;
    logic [31:0]       crc_next;
    logic              out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (r_step[STEP_W-1:3])
            2'd0:    seed_word = r_id_low;
            2'd1:    seed_word = r_id_high;
            default: seed_word = r_loc;
        endcase
    end
    assign seed_byte = seed_word[{r_step[2:0], 3'b000} +: 8];

    assign take      = i_cmd.take_plain || i_cmd.take_held;
    assign cur_byte  = i_cmd.take_held ? r_held_byte : i_data_byte;
    assign cur_last  = i_cmd.take_held ? r_held_last : i_last;
    assign need      = {1'b0, r_offset} + FIELD_LEN;
    assign in_window = (r_pos >= {1'b0, r_offset}) && (r_pos < need);
    assign pos_next  = (r_pos == POS_MAX) ? r_pos : r_pos + POS_W'(1);
    assign crc_next  = crc_byte(r_crc, in_window ? 8'd0 : cur_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_low    <= '0;
            r_id_high   <= '0;
            r_offset    <= '0;
            r_crc       <= CRC_INIT;
            r_pos       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_held_last <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_VOLUME_ID_LOW:   r_id_low  <= i_cfg_data;
                    CFG_VOLUME_ID_HIGH:  r_id_high <= i_cfg_data;
                    CFG_CHECKSUM_OFFSET: r_offset  <= i_cfg_data[OFF_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_first) begin
                r_crc       <= CRC_INIT;
                r_pos       <= '0;
                r_step      <= '0;
                r_held_last <= i_last;
            end else if (i_cmd.seed) begin
                r_crc  <= crc_byte(r_crc, seed_byte);
                r_step <= r_step + STEP_W'(1);
            end else if (take) begin
                r_crc <= crc_next;
                r_pos <= pos_next;
            end
            if (take && cur_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_first) begin
            r_loc       <= i_location;
            r_held_byte <= i_data_byte;
        end
        if (take && cur_last) begin
            r_valid_res <= (pos_next >= need);
            r_checksum  <= (pos_next >= need) ? ~crc_next : 32'd0;
        end
    end

    assign o_status.seed_done = (r_step == SEED_LAST);
    assign o_status.held_last = r_held_last;
    assign o_status.out_free  = out_free;
    assign o_out_valid        = r_out_valid;
    assign o_checksum         = r_checksum;
    assign o_valid_res        = r_valid_res;

endmodule
`default_nettype wire

[src/seeded_struct_crc32c.sv]
// top level of the seeded crc-32c structure checksum block
// a last byte's result is registered as the byte is taken, valid the cycle after
// a first byte holds the input for load, the 24 seed bytes, then the held byte
// throughput: one plain byte per cycle, set by the single-byte crc update on the crc register
// a result waiting on the output stalls the input until it is taken
// synchronous active-low reset: crc to all ones, count and config to zero, no result pending
`timescale 1ns / 1ps
`default_nettype none
module seeded_struct_crc32c
    import sscrc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    sscrc_in_if.sink                   s_in,
    sscrc_out_if.source                m_out
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign s_in.ready = in_ready;

    sscrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_in.valid),
        .i_in_first (s_in.first),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    sscrc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_data_byte (s_in.data_byte),
        .i_last      (s_in.last),
        .i_location  (s_in.location),
        .i_cmd       (cmd),
        .i_out_ready (m_out.ready),
        .o_status    (status),
        .o_out_valid (m_out.valid),
        .o_checksum  (m_out.checksum),
        .o_valid_res (m_out.valid_res)
    );

endmodule
`default_nettype wire

[test/sscrc_checker.sv]
// checker: follows the byte stream and register writes, predicts each checksum and compares
`timescale 1ns / 1ps
module sscrc_checker
    import sscrc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sscrc_in_if                   in_mon,
    sscrc_out_if                  out_mon,
    input  logic                  i_final,
    output int                    o_failures,
    output int                    o_pending,
    output int                    o_checked
);

    typedef struct packed {
        logic [31:0] checksum;
        logic        valid_res;
    } digest_t;

    logic [63:0]      id_low;
    logic [63:0]      id_high;
    logic [OFF_W-1:0] field_offset;
    logic [31:0]      crc_acc;
    logic [POS_W-1:0] bytes_seen;
    digest_t          digest_q[$];
    int               mismatches = 0;
    int               checked_count = 0;

    // one reflected crc-32c step, fed one data bit at a time
    function automatic logic [31:0] crc32c_shift(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ b[k];
            r  = {1'b0, r[31:1]};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] crc32c_word(input logic [31:0] c, input logic [63:0] w);
        logic [31:0] r;
        r = c;
        for (int k = 0; k < 8; k++) begin
            r = crc32c_shift(r, w[8*k +: 8]);
        end
        return r;
    endfunction

    task automatic take_byte(input logic [7:0] d, input logic f, input logic l,
                             input logic [63:0] loc);
        int unsigned need;
        int unsigned pos;
        logic [7:0]  hashed;
        digest_t     dg;
        need = int'(field_offset) + 4;
        if (f) begin
            crc_acc    = CRC_INIT;
            crc_acc    = crc32c_word(crc_acc, id_low);
            crc_acc    = crc32c_word(crc_acc, id_high);
            crc_acc    = crc32c_word(crc_acc, loc);
            bytes_seen = '0;
        end
        pos    = int'(bytes_seen);
        // checksum field bytes count as zeros
        hashed = (pos >= int'(field_offset) && pos < need) ? 8'h00 : d;
        crc_acc = crc32c_shift(crc_acc, hashed);
        if (pos < MAX_STRUCT_BYTES) begin
            bytes_seen = bytes_seen + 1'b1;
        end
        if (l) begin
            if (int'(bytes_seen) >= need) begin
                dg.checksum  = ~crc_acc;
                dg.valid_res = 1'b1;
            end else begin
                dg.checksum  = 32'h0;
                dg.valid_res = 1'b0;
            end
            digest_q.push_back(dg);
        end
    endtask

    task automatic compare_result();
        digest_t dg;
        if (digest_q.size() == 0) begin
            $error("result with no item pending: checksum %h valid_res %b",
                   out_mon.checksum, out_mon.valid_res);
            mismatches++;
        end else begin
            dg = digest_q.pop_front();
            checked_count++;
            if (out_mon.checksum !== dg.checksum) begin
                $error("checksum mismatch: expected %h, actual %h", dg.checksum,
                       out_mon.checksum);
                mismatches++;
            end
            if (out_mon.valid_res !== dg.valid_res) begin
                $error("valid_res mismatch: expected %b, actual %b", dg.valid_res,
                       out_mon.valid_res);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            id_low       = '0;
            id_high      = '0;
            field_offset = '0;
            crc_acc      = CRC_INIT;
            bytes_seen   = '0;
            digest_q.delete();
        end else begin
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_index)
                    CFG_VOLUME_ID_LOW: begin
                        id_low = i_cfg_data;
                    end
                    CFG_VOLUME_ID_HIGH: begin
                        id_high = i_cfg_data;
                    end
                    CFG_CHECKSUM_OFFSET: begin
                        field_offset = i_cfg_data[OFF_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // results leave before the item of this edge is predicted
            if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
                compare_result();
            end
            if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
                take_byte(in_mon.data_byte, in_mon.first, in_mon.last, in_mon.location);
            end
        end
        o_pending <= digest_q.size();
        o_checked <= checked_count;
    end

    assign o_failures = mismatches + (i_final ? o_pending : 0);

endmodule

[test/testbench.sv]
// top: drives structure bytes and register writes, applies back-pressure, gives the verdict
`timescale 1ns / 1ps
module testbench;
    import sscrc_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  final_check;
    int                    failures;
    int                    pending;
    int                    checked;

    bit     quiet = 1'b0;
    bit     sender_gaps = 1'b1;
    int     cur_offset = 0;
    int     bytes_sent = 0;
    int     structs_sent = 0;
    int     settings_used = 0;
    longint cycle_count = 0;

    sscrc_in_if  in_ch();
    sscrc_out_if out_ch();

    seeded_struct_crc32c DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .s_in        (in_ch),
        .m_out       (out_ch)
    );

    sscrc_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .i_final     (final_check),
        .o_failures  (failures),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stall bursts, none once the run goes quiet
    initial begin
        int hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else begin
                if (!quiet && hold == 0 && $urandom_range(0, 5) == 0) begin
                    hold = $urandom_range(1, 10);
                end
                if (hold > 0 && !quiet) begin
                    out_ch.ready <= 1'b0;
                    hold--;
                end else begin
                    out_ch.ready <= 1'b1;
                    hold = 0;
                end
            end
        end
    end

    function automatic logic [63:0] rand_loc();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int len_pick();
        int need;
        need = cur_offset + 4;
        if (need > 40) begin
            return $urandom_range(1, 40);
        end
        case ($urandom_range(0, 5))
            0: return 1;
            1: return need - 1;
            2: return need;
            default: return need + $urandom_range(0, 12);
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic push_item(input logic [7:0] d, input logic f, input logic l,
                             input logic [63:0] loc);
        if (sender_gaps && !quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= d;
        in_ch.first     <= f;
        in_ch.last      <= l;
        in_ch.location  <= loc;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_struct(input int len, input logic [63:0] loc, input bit closed);
        for (int i = 0; i < len; i++) begin
            push_item(rand_byte(), i == 0, closed && i == len - 1, i == 0 ? loc : rand_loc());
        end
        if (closed) begin
            structs_sent++;
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic [63:0] id_lo, input logic [63:0] id_hi,
                                 input int off);
        settle();
        put_reg(CFG_VOLUME_ID_LOW, id_lo);
        put_reg(CFG_VOLUME_ID_HIGH, id_hi);
        put_reg(CFG_CHECKSUM_OFFSET, CFG_DATA_W'(off));
        cfg_we <= 1'b0;
        cur_offset = off;
        settings_used++;
    endtask

    // mostly framed structures, with loose bytes, unterminated ones and full drains mixed in
    task automatic random_run(input int n_items);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_items) begin
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 4)) begin
                        push_item(rand_byte(), 1'b0, $urandom_range(0, 3) == 0, rand_loc());
                    end
                end
                1: send_struct(len_pick(), rand_loc(), 1'b0);
                2: begin
                    drain();
                    send_struct(len_pick(), rand_loc(), 1'b1);
                end
                default: send_struct(len_pick(), rand_loc(), 1'b1);
            endcase
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        final_check     = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.first     = 1'b0;
        in_ch.last      = 1'b0;
        in_ch.location  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset config: bytes before any first hash into the unseeded crc
        push_item(8'h00, 1'b0, 1'b0, '1);
        push_item(8'hFF, 1'b0, 1'b0, 64'h0);
        push_item(8'h5A, 1'b0, 1'b0, '1);
        push_item(8'hA5, 1'b0, 1'b0, 64'h0);
        push_item(8'h3C, 1'b0, 1'b1, '1);
        // no first after last: the structure carries on
        push_item(8'h81, 1'b0, 1'b0, 64'h0);
        push_item(8'h7E, 1'b0, 1'b1, '1);
        // one-byte structure, never long enough
        push_item(8'hFF, 1'b1, 1'b1, '1);
        // one byte short, then exactly offset plus four
        push_item(8'h00, 1'b1, 1'b0, 64'h0);
        push_item(8'h01, 1'b0, 1'b0, '1);
        push_item(8'h80, 1'b0, 1'b1, '1);
        push_item(8'hFF, 1'b1, 1'b0, '1);
        push_item(8'hFF, 1'b0, 1'b0, 64'h0);
        push_item(8'hFF, 1'b0, 1'b0, 64'h0);
        push_item(8'hFF, 1'b0, 1'b1, 64'h0);
        structs_sent += 3;

        apply_setting('1, '1, 2);
        send_struct(8, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        send_struct(6, 64'h5555_5555_5555_5555, 1'b1);

        apply_setting({$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 24));
        random_run(180);
        apply_setting('1, '1, 0);
        random_run(180);
        apply_setting(64'h0, 64'h0, 65532);
        random_run(120);
        apply_setting({$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(1, 8));
        random_run(180);

        apply_setting({$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 16));
        quiet = 1'b1;
        random_run(180);
        send_struct(cur_offset + 6, rand_loc(), 1'b1);
        settle();

        final_check = 1'b1;
        @(negedge i_clk);
        $display("covered %0d bytes in %0d framed structures, %0d checksums compared",
                 bytes_sent, structs_sent, checked);
        $display("%0d register settings, checksum offsets from 0 up to 65532",
                 settings_used);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
